// ===== src/igpl_pkg.sv =====
// Shared types and constants for the imbalance gated profit lock unit.
package igpl_pkg;

	// Configuration port geometry
	localparam int unsigned CFG_IDX_W  = 8;
	localparam int unsigned CFG_DATA_W = 16;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ARM_RATIO      = 8'd0,
		CFG_GIVEBACK_RATIO = 8'd1,
		CFG_LOCK_RATIO     = 8'd2,
		CFG_HOSTILE_LEVEL  = 8'd3
	} cfg_reg_t;

	// Register reset values
	localparam logic [15:0] ARM_RATIO_RST      = 16'd256;
	localparam logic [15:0] GIVEBACK_RATIO_RST = 16'd102;
	localparam logic [15:0] LOCK_RATIO_RST     = 16'd128;
	localparam logic [15:0] HOSTILE_LEVEL_RST  = 16'd22938;

	// Widths of the internal arithmetic
	localparam int unsigned PRICE_W = 32;
	localparam int unsigned PROD_W  = 49;  // Q8.8 ratio times 32-bit signed tick count
	localparam int unsigned OFF_W   = 41;  // rounded lock offset
	localparam int unsigned LOCK_W  = 42;  // peak plus or minus offset
	localparam int unsigned ENTRY_W = 34;
	localparam int unsigned GAIN_W  = 40;

	// One sample after the input register, with its ratio products done
	typedef struct packed {
		logic                      first;
		logic                      last;
		logic                      long_side;
		logic signed [PRICE_W-1:0] bid;
		logic signed [PRICE_W-1:0] ask;
		logic [15:0]               imb;
		logic signed [PRICE_W-1:0] fav;
		logic                      pos_ok;     // risk and ATR of the position both positive
		logic signed [PROD_W-1:0]  arm_prod;   // arm_ratio * risk
		logic signed [PROD_W-1:0]  give_prod;  // giveback_ratio * atr
		logic signed [OFF_W-1:0]   lock_off;   // (lock_ratio * atr + 128) >> 8
	} item_t;

	// One result for a closed position
	typedef struct packed {
		logic signed [GAIN_W-1:0] gain;
		logic                     hit;
		logic                     usable;
	} result_t;

endpackage

// ===== src/igpl_core.sv =====
// Position state and the single-pass tracking update for one sample.
module igpl_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  igpl_pkg::item_t     item,
	input  logic [15:0]         hostile_level,
	output logic                res_valid,
	output igpl_pkg::result_t   res
);

	// Position state
	logic                                     armed_q, locked_q, hit_q, done_q;
	logic                                     side_q;
	logic signed [igpl_pkg::PRICE_W-1:0]      peak_q;
	logic signed [igpl_pkg::LOCK_W-1:0]       lock_q;
	logic signed [igpl_pkg::ENTRY_W-1:0]      entry_q;

	// State as seen by this sample after a possible restart
	logic                                     side_c, armed_c, locked_c, hit_c;
	logic signed [igpl_pkg::PRICE_W-1:0]      peak_c;
	logic signed [igpl_pkg::LOCK_W-1:0]       lock_c;

	// Next state
	logic                                     armed_n, locked_n, hit_n, cnt_n;
	logic signed [igpl_pkg::PRICE_W-1:0]      peak_n;
	logic signed [igpl_pkg::LOCK_W-1:0]       lock_n;
	logic signed [igpl_pkg::ENTRY_W-1:0]      entry_n;

	// Tracking terms
	logic                                     live, active, reach, newly, hostile, trig;
	logic                                     better, tighter, through, usable;
	logic signed [igpl_pkg::PRICE_W-1:0]      px;
	logic signed [igpl_pkg::PRICE_W:0]        give;
	logic signed [igpl_pkg::LOCK_W-1:0]       lv;
	logic signed [igpl_pkg::LOCK_W:0]         gain_raw;
	logic signed [igpl_pkg::GAIN_W-1:0]       gain_sat;

	// Restart view, sample count and entry price
	always_comb begin
		live     = item.first | ~done_q;
		side_c   = item.first ? item.long_side : side_q;
		armed_c  = item.first ? 1'b0 : armed_q;
		locked_c = item.first ? 1'b0 : locked_q;
		hit_c    = item.first ? 1'b0 : hit_q;
		peak_c   = item.first ? '0 : peak_q;
		lock_c   = item.first ? '0 : lock_q;
		cnt_n    = item.first ? 1'b0 : 1'b1;
		if (item.first) begin
			entry_n = item.long_side
				? igpl_pkg::ENTRY_W'(item.bid) - igpl_pkg::ENTRY_W'(item.fav)
				: igpl_pkg::ENTRY_W'(item.ask) + igpl_pkg::ENTRY_W'(item.fav);
		end else begin
			entry_n = entry_q;
		end
	end

	// Arm, peak, lock and hit update
	always_comb begin
		active  = live & item.pos_ok & ~hit_c;
		reach   = $signed({{9{item.fav[igpl_pkg::PRICE_W-1]}}, item.fav, 8'h00})
			>= item.arm_prod;
		newly   = reach & ~armed_c;
		px      = side_c ? item.bid : item.ask;
		better  = side_c ? (px > peak_c) : (px < peak_c);
		hostile = side_c ? ({1'b0, item.imb} <= {1'b0, hostile_level})
			: ({1'b0, item.imb} >= (17'h10000 - {1'b0, hostile_level}));

		armed_n  = armed_c;
		peak_n   = peak_c;
		lock_n   = lock_c;
		locked_n = locked_c;
		hit_n    = hit_c;
		give     = '0;
		lv       = '0;
		trig     = 1'b0;
		tighter  = 1'b0;
		through  = 1'b0;

		if (active) begin
			armed_n = armed_c | reach;
			if (armed_n) begin
				if (newly || better) begin
					peak_n = px;
				end
				give = side_c ? (($bits(give))'(peak_n) - ($bits(give))'(px))
					: (($bits(give))'(px) - ($bits(give))'(peak_n));
				trig = hostile
					&& ($signed({{8{give[igpl_pkg::PRICE_W]}}, give, 8'h00})
					>= item.give_prod);
				lv = side_c
					? igpl_pkg::LOCK_W'(peak_n) - igpl_pkg::LOCK_W'(item.lock_off)
					: igpl_pkg::LOCK_W'(peak_n) + igpl_pkg::LOCK_W'(item.lock_off);
				tighter = side_c ? (lv > lock_c) : (lv < lock_c);
				if (trig && (!locked_c || tighter)) begin
					lock_n = lv;
				end
				locked_n = locked_c | trig;
				through  = locked_n
					&& (side_c ? (igpl_pkg::LOCK_W'(item.bid) <= lock_n)
					: (igpl_pkg::LOCK_W'(item.ask) >= lock_n));
				hit_n = hit_c | through;
			end
		end
	end

	// Result for the last sample
	always_comb begin
		usable   = cnt_n & item.pos_ok;
		gain_raw = side_c
			? ($bits(gain_raw))'(lock_n) - ($bits(gain_raw))'(entry_n)
			: ($bits(gain_raw))'(entry_n) - ($bits(gain_raw))'(lock_n);
		// clamp to the 40-bit signed range
		if (gain_raw > $signed(($bits(gain_raw))'({1'b0,
				{(igpl_pkg::GAIN_W-1){1'b1}}}))) begin
			gain_sat = {1'b0, {(igpl_pkg::GAIN_W-1){1'b1}}};
		end else if (gain_raw < ($bits(gain_raw))'(signed'({1'b1,
				{(igpl_pkg::GAIN_W-1){1'b0}}}))) begin
			gain_sat = {1'b1, {(igpl_pkg::GAIN_W-1){1'b0}}};
		end else begin
			gain_sat = gain_raw[igpl_pkg::GAIN_W-1:0];
		end

		res_valid  = live & item.last;
		res.usable = usable;
		res.hit    = usable & hit_n;
		if (!usable) begin
			res.gain = '0;
		end else if (hit_n) begin
			res.gain = gain_sat;
		end else begin
			res.gain = igpl_pkg::GAIN_W'(item.fav);
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q   <= 1'b0;
			locked_q  <= 1'b0;
			hit_q     <= 1'b0;
			done_q    <= 1'b1;
			side_q    <= 1'b0;
			peak_q    <= '0;
			lock_q    <= '0;
			entry_q   <= '0;
		end else if (fire && live) begin
			armed_q   <= armed_n;
			locked_q  <= locked_n;
			hit_q     <= hit_n;
			done_q    <= item.last;
			side_q    <= side_c;
			peak_q    <= peak_n;
			lock_q    <= lock_n;
			entry_q   <= entry_n;
		end
	end

endmodule

// ===== src/imbalance_gated_profit_lock_unit.sv =====
// Top level of the imbalance gated profit lock unit: ports, config, input and result registers.
//
// Takes one market sample per cycle and emits one result per position on its last sample.
// The three Q8.8 ratio products (arm times risk, giveback times ATR, rounded lock offset)
// are formed by one multiplier each as a request is taken and are held with it in the input
// register; one combinational update of the position state then loads the result register,
// so the result of a position is registered once its last sample leaves the input register.
// Throughput is one sample per cycle as long as the result side takes results; a held result
// stalls the input register and then in_ready. Configuration writes are always taken
// (cfg_ready is high) and must be made while no position is in flight. There is no clearing
// pass after reset.
module imbalance_gated_profit_lock_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [igpl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [igpl_pkg::CFG_DATA_W-1:0]    cfg_data,
	// samples
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               first_sample,
	input  logic                               last_sample,
	input  logic signed [31:0]                 bid_price,
	input  logic signed [31:0]                 ask_price,
	input  logic [15:0]                        imbalance,
	input  logic signed [31:0]                 favourable_move,
	input  logic signed [31:0]                 risk_ticks,
	input  logic signed [31:0]                 atr_ticks,
	input  logic                               long_side,
	// results
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [39:0]                 protect_gain,
	output logic                               lock_hit,
	output logic                               usable
);

	// Configuration registers
	logic [15:0] arm_ratio_q, giveback_ratio_q, lock_ratio_q, hostile_level_q;

	// Risk and ATR of the most recently accepted position
	logic signed [31:0] risk_q, atr_q;

	// Input stage
	logic                                  s1_valid;
	igpl_pkg::item_t                       item_s1;
	igpl_pkg::item_t                       item_c;
	logic signed [31:0]                    op_risk, op_atr;
	logic signed [igpl_pkg::PROD_W-1:0]    lock_prod;
	logic signed [igpl_pkg::PROD_W-1:0]    lock_rnd;

	// Result stage
	logic                                  out_valid_q;
	igpl_pkg::result_t                     res_q;
	igpl_pkg::result_t                     res_c;
	logic                                  res_valid_c;
	logic                                  advance, fire, in_fire;

	// Handshake and stage advance
	assign cfg_ready = 1'b1;
	assign advance   = ~out_valid_q | out_ready;
	assign fire      = s1_valid & advance;
	assign in_ready  = ~s1_valid | advance;
	assign in_fire   = in_valid & in_ready;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_ratio_q      <= igpl_pkg::ARM_RATIO_RST;
			giveback_ratio_q <= igpl_pkg::GIVEBACK_RATIO_RST;
			lock_ratio_q     <= igpl_pkg::LOCK_RATIO_RST;
			hostile_level_q  <= igpl_pkg::HOSTILE_LEVEL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				igpl_pkg::CFG_ARM_RATIO:      arm_ratio_q      <= cfg_data;
				igpl_pkg::CFG_GIVEBACK_RATIO: giveback_ratio_q <= cfg_data;
				igpl_pkg::CFG_LOCK_RATIO:     lock_ratio_q     <= cfg_data;
				igpl_pkg::CFG_HOSTILE_LEVEL:  hostile_level_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Ratio products for the incoming request, using the position it belongs to
	always_comb begin
		op_risk   = first_sample ? risk_ticks : risk_q;
		op_atr    = first_sample ? atr_ticks : atr_q;
		lock_prod = $signed({1'b0, lock_ratio_q}) * op_atr;
		lock_rnd  = lock_prod + igpl_pkg::PROD_W'(128);

		item_c.first     = first_sample;
		item_c.last      = last_sample;
		item_c.long_side = long_side;
		item_c.bid       = bid_price;
		item_c.ask       = ask_price;
		item_c.imb       = imbalance;
		item_c.fav       = favourable_move;
		item_c.pos_ok    = (op_risk > 32'sd0) && (op_atr > 32'sd0);
		item_c.arm_prod  = $signed({1'b0, arm_ratio_q}) * op_risk;
		item_c.give_prod = $signed({1'b0, giveback_ratio_q}) * op_atr;
		item_c.lock_off  = lock_rnd[igpl_pkg::PROD_W-1:8];
	end

	// Position risk and ATR follow accepted first samples
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			risk_q <= '0;
			atr_q  <= '0;
		end else if (in_fire && first_sample) begin
			risk_q <= risk_ticks;
			atr_q  <= atr_ticks;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (in_ready) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= item_c;
		end
	end

	// Position state and tracking
	igpl_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.item          (item_s1),
		.hostile_level (hostile_level_q),
		.res_valid     (res_valid_c),
		.res           (res_c)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire & res_valid_c;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid_c) begin
			res_q <= res_c;
		end
	end

	assign out_valid    = out_valid_q;
	assign protect_gain = res_q.gain;
	assign lock_hit     = res_q.hit;
	assign usable       = res_q.usable;

	// A stalled input register keeps its request
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !advance |=> s1_valid)
		else $error("input register dropped a stalled request");

	// An empty result register never blocks the input side
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input blocked while result register empty");

	// A lock hit is only reported for a usable position
	a_hit_usable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!lock_hit || usable))
		else $error("lock hit on unusable position");

	// An unusable position reports zero gain
	a_zero_gain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !usable |-> protect_gain == '0)
		else $error("nonzero gain on unusable position");

endmodule
